[hw/rtl/vrrb_pkg.sv]
package vrrb_pkg;

    localparam int DEFAULT_STORE_WORDS = 4096;
    localparam int POS_W  = 13;
    localparam int LEN_W  = 12;
    localparam int CNT_W  = 12;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int CAP_MIN = 3;
    localparam int CAP_RESET = 4096;
    localparam int HDR_WORDS = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 120;

    localparam logic [MODE_W-1:0] MODE_LINEAR      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRAPPED     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GAP         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRAP_HOLD   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_WRAPPED = 3'd4;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_WORD   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_EMPTY     = 4'd1,
        ST_FULL      = 4'd2,
        ST_TOO_LARGE = 4'd3,
        ST_MODE_ERR  = 4'd4,
        ST_WRAP_PEND = 4'd5,
        ST_NO_OPEN   = 4'd6,
        ST_ZERO_HEAD = 4'd7,
        ST_BUSY      = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_HDR, S_LINK, S_RHDR, S_RDATA, S_RLINK, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MEM_NONE, MEM_WR_PATCH, MEM_WR_HDR, MEM_WR_LINK, MEM_WR_DATA,
        MEM_RD_HDR, MEM_RD_DATA, MEM_RD_LINK
    } t_mem_op;

    typedef enum logic [3:0] {
        UPD_NONE, UPD_BEGIN, UPD_WORD, UPD_STRAY, UPD_EMPTY, UPD_CLEAR,
        UPD_HEAD, UPD_READ, UPD_LINK
    } t_upd;

    typedef struct packed {
        logic    load_in;
        t_mem_op mem;
        t_upd    upd;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic bg_place;
        logic bg_wrap;
        logic open;
        logic queued;
        logic head_bad;
        logic read_last;
        logic out_free;
    } t_dp_stat;

endpackage

[hw/rtl/variable_record_ring_buffer_core.sv]
// Ring buffer of variable-length records in a single-port-per-direction word store.
// Each input word is a command (tuser: 0 insert begin, 1 insert word, 2 remove
// word, 3 clear) and returns exactly one result word. One command is handled at
// a time. Insert begin adds header and link writes, plus a link patch on wrap;
// remove adds a header read, a data read and a link read at record end. The
// store gives one write and one registered read access per cycle. A new
// command is taken while the previous result still waits on the output.
// The user must write capacity_words only while no command is in flight; the
// block itself does not enforce this.
module variable_record_ring_buffer_core
    import vrrb_pkg::*;
#(
    parameter int STORE_WORDS = DEFAULT_STORE_WORDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // record_length[11:0], data_word[43:12]
    input  logic [1:0]           i_s_tuser,   // command[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // read_word[31:0], head_length[43:32],
                                              // records_queued[55:44],
                                              // inserts_total[87:56],
                                              // removes_total[119:88]
    output logic [3:0]           o_m_tuser,   // status[3:0]
    output logic                 o_m_tlast,
    input  logic                 i_cfg_wr_en,
    input  logic [POS_W-1:0]     i_cfg_wr_data
);
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    vrrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    vrrb_datapath #(.STORE_WORDS(STORE_WORDS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );
endmodule

[hw/rtl/vrrb_ram.sv]
module vrrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

[hw/rtl/vrrb_ctrl.sv]
module vrrb_ctrl
    import vrrb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_EXEC;
            S_EXEC: begin
                unique case (i_stat.cmd)
                    CMD_BEGIN: begin
                        if (i_stat.bg_place && i_stat.bg_wrap) n_state = S_HDR;
                        else if (i_stat.bg_place) n_state = S_LINK;
                        else n_state = S_OUT;
                    end
                    CMD_REMOVE: n_state = i_stat.queued ? S_RHDR : S_OUT;
                    default:    n_state = S_OUT;
                endcase
            end
            S_HDR:   n_state = S_LINK;
            S_LINK:  n_state = S_OUT;
            S_RHDR:  n_state = i_stat.head_bad ? S_OUT : S_RDATA;
            S_RDATA: n_state = i_stat.read_last ? S_RLINK : S_OUT;
            S_RLINK: n_state = S_OUT;
            S_OUT:   if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{load_in: 1'b0, mem: MEM_NONE, upd: UPD_NONE, load_out: 1'b0};
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            S_EXEC: begin
                unique case (i_stat.cmd)
                    CMD_BEGIN: begin
                        // wrap placement patches the previous link first
                        if (i_stat.bg_place && i_stat.bg_wrap) o_cmd.mem = MEM_WR_PATCH;
                        else if (i_stat.bg_place) o_cmd.mem = MEM_WR_HDR;
                        else o_cmd.upd = UPD_BEGIN;
                    end
                    CMD_WORD: begin
                        if (i_stat.open) begin
                            o_cmd.mem = MEM_WR_DATA;
                            o_cmd.upd = UPD_WORD;
                        end else begin
                            o_cmd.upd = UPD_STRAY;
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_stat.queued) o_cmd.mem = MEM_RD_HDR;
                        else o_cmd.upd = UPD_EMPTY;
                    end
                    default: o_cmd.upd = UPD_CLEAR;
                endcase
            end
            S_HDR: o_cmd.mem = MEM_WR_HDR;
            S_LINK: begin
                o_cmd.mem = MEM_WR_LINK;
                o_cmd.upd = UPD_BEGIN;
            end
            S_RHDR: begin
                o_cmd.upd = UPD_HEAD;
                if (!i_stat.head_bad) o_cmd.mem = MEM_RD_DATA;
            end
            S_RDATA: begin
                o_cmd.upd = UPD_READ;
                if (i_stat.read_last) o_cmd.mem = MEM_RD_LINK;
            end
            S_RLINK: o_cmd.upd = UPD_LINK;
            S_OUT:   o_cmd.load_out = i_stat.out_free;
            default: ;
        endcase
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted word not executed");
    a_link_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (r_state == S_OUT))
        else $error("link write not followed by result");
    a_no_mem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> (o_cmd.mem == MEM_NONE))
        else $error("store access outside a command");
endmodule

[hw/rtl/vrrb_datapath.sv]
module vrrb_datapath
    import vrrb_pkg::*;
#(
    parameter int STORE_WORDS = DEFAULT_STORE_WORDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [1:0]           i_s_tuser,
    input  logic                 i_cfg_wr_en,
    input  logic [POS_W-1:0]     i_cfg_wr_data,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [3:0]           o_m_tuser,
    output logic                 o_m_tlast
);
    localparam int AW  = $clog2(STORE_WORDS);
    localparam int AXW = POS_W + 2;

    logic [POS_W-1:0]  r_cap, r_wp, r_rp, r_last, r_fill, r_off;
    logic [LEN_W-1:0]  r_open;
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_acc, r_rem;

    t_cmd              r_cmd;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_head;
    logic              r_rd_oob;

    t_status           r_res_status;
    logic [DATA_W-1:0] r_res_word;
    logic              r_res_last;
    logic [LEN_W-1:0]  r_res_hlen;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [3:0]           r_m_tuser;
    logic                 r_m_tlast;

    // insert-begin decision
    logic [POS_W-1:0] cap_eff, need, bg_p, new_wp;
    logic [POS_W:0]   w_need, r_need_sum, need_w;
    t_status          bg_status;
    logic             bg_place, bg_wrap, bg_mode_set, ahead;
    logic [MODE_W-1:0] bg_mode;

    always_comb begin
        cap_eff = r_cap;
        if (32'(r_cap) < CAP_MIN) cap_eff = POS_W'(CAP_MIN);
        if (32'(r_cap) > STORE_WORDS) cap_eff = POS_W'(STORE_WORDS);
        need       = POS_W'(r_len) + POS_W'(HDR_WORDS);
        w_need     = {1'b0, r_wp} + {1'b0, need};
        r_need_sum = {1'b0, r_rp} + {1'b0, need};
        need_w     = w_need;
        ahead      = r_wp > r_rp;
        bg_status   = ST_OK;
        bg_place    = 1'b0;
        bg_wrap     = 1'b0;
        bg_p        = r_wp;
        bg_mode_set = 1'b0;
        bg_mode     = MODE_LINEAR;
        if (r_open != '0) begin
            bg_status = ST_BUSY;
        end else if (r_count == '0) begin
            bg_p = '0;
            if (need > cap_eff) begin
                bg_status = ST_TOO_LARGE;
            end else begin
                bg_place    = 1'b1;
                bg_mode_set = 1'b1;
            end
        end else if (ahead) begin
            if (r_mode == MODE_WRAP_HOLD) begin
                bg_status = ST_WRAP_PEND;
            end else if (r_mode != MODE_LINEAR && r_mode != MODE_READ_WRAPPED) begin
                bg_status = ST_MODE_ERR;
            end else begin
                bg_mode_set = 1'b1;
                if (need_w < {1'b0, cap_eff}) begin
                    bg_place = 1'b1;
                end else if (r_rp >= need) begin
                    bg_place = 1'b1;
                    bg_wrap  = 1'b1;
                    bg_p     = '0;
                    bg_mode  = MODE_WRAPPED;
                end else begin
                    bg_status = ST_FULL;
                end
            end
        end else if (w_need < {1'b0, r_rp} && r_need_sum < {1'b0, cap_eff}) begin
            if (r_mode != MODE_WRAPPED && r_mode != MODE_GAP && r_mode != MODE_WRAP_HOLD) begin
                bg_status = ST_MODE_ERR;
            end else begin
                bg_place    = 1'b1;
                bg_mode_set = 1'b1;
                bg_mode     = MODE_GAP;
            end
        end else begin
            bg_status = ST_FULL;
        end
        new_wp = bg_p + need;
    end

    // store ports
    logic [AXW-1:0]    waddr_raw, raddr_raw;
    logic [DATA_W-1:0] wdata, ram_q, rdata;
    logic              we_req;

    always_comb begin
        we_req    = 1'b0;
        waddr_raw = AXW'(r_fill);
        wdata     = r_data;
        raddr_raw = AXW'(r_rp);
        case (i_cmd.mem)
            MEM_WR_PATCH: begin
                we_req    = 1'b1;
                waddr_raw = AXW'(r_last) + AXW'(1);
                wdata     = '0;
            end
            MEM_WR_HDR: begin
                we_req    = 1'b1;
                waddr_raw = AXW'(bg_p);
                wdata     = DATA_W'(r_len);
            end
            MEM_WR_LINK: begin
                we_req    = 1'b1;
                waddr_raw = AXW'(bg_p) + AXW'(1);
                wdata     = DATA_W'(new_wp);
            end
            MEM_WR_DATA: we_req = 1'b1;
            MEM_RD_DATA: raddr_raw = AXW'(r_rp) + AXW'(HDR_WORDS) + AXW'(r_off);
            MEM_RD_LINK: raddr_raw = AXW'(r_rp) + AXW'(1);
            default: ;
        endcase
    end

    vrrb_ram #(.WIDTH(DATA_W), .DEPTH(STORE_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we_req && (32'(waddr_raw) < STORE_WORDS)),
        .i_waddr (AW'(waddr_raw)),
        .i_wdata (wdata),
        .i_raddr (AW'(raddr_raw)),
        .o_rdata (ram_q)
    );

    assign rdata = r_rd_oob ? '0 : ram_q;

    logic head_bad, read_last;
    logic [POS_W-1:0] link_pos;
    assign head_bad  = (rdata == '0) || rdata[DATA_W-1];
    // read offset wraps at the position width before the compare
    assign read_last = DATA_W'(POS_W'(r_off + 1'b1)) >= r_head;
    assign link_pos  = rdata[POS_W-1:0];

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.bg_place  = bg_place;
        o_stat.bg_wrap   = bg_wrap;
        o_stat.open      = r_open != '0;
        o_stat.queued    = r_count != '0;
        o_stat.head_bad  = head_bad;
        o_stat.read_last = read_last;
        o_stat.out_free  = !r_m_tvalid || i_m_tready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= POS_W'(CAP_RESET);
            r_wp       <= '0;
            r_rp       <= '0;
            r_last     <= '0;
            r_fill     <= '0;
            r_off      <= '0;
            r_open     <= '0;
            r_mode     <= MODE_LINEAR;
            r_count    <= '0;
            r_acc      <= '0;
            r_rem      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
            if (i_cmd.load_out) r_m_tvalid <= 1'b1;
            else if (i_m_tready) r_m_tvalid <= 1'b0;
            case (i_cmd.upd)
                UPD_BEGIN: begin
                    if (r_open == '0 && r_count == '0) begin
                        r_rp  <= '0;
                        r_off <= '0;
                    end
                    if (bg_mode_set) r_mode <= bg_mode;
                    if (bg_place) begin
                        r_last <= bg_p;
                        r_wp   <= new_wp;
                        r_fill <= bg_p + POS_W'(HDR_WORDS);
                        r_open <= r_len;
                        if (r_len == '0) begin
                            r_count <= r_count + 1'b1;
                            r_acc   <= r_acc + 1'b1;
                        end
                    end else if (r_open == '0 && r_count == '0) begin
                        r_wp <= '0;
                    end
                end
                UPD_WORD: begin
                    r_fill <= r_fill + 1'b1;
                    r_open <= r_open - 1'b1;
                    if (r_open == LEN_W'(1)) begin
                        r_count <= r_count + 1'b1;
                        r_acc   <= r_acc + 1'b1;
                    end
                end
                UPD_READ: r_off <= r_off + 1'b1;
                UPD_LINK: begin
                    r_rp    <= link_pos;
                    r_off   <= '0;
                    if (link_pos == '0) r_mode <= MODE_READ_WRAPPED;
                    r_count <= r_count - 1'b1;
                    r_rem   <= r_rem + 1'b1;
                end
                UPD_CLEAR: begin
                    r_wp    <= '0;
                    r_rp    <= '0;
                    r_last  <= '0;
                    r_count <= '0;
                    r_acc   <= '0;
                    r_rem   <= '0;
                    r_open  <= '0;
                    r_fill  <= '0;
                    r_off   <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_oob <= !(32'(raddr_raw) < STORE_WORDS);
        if (i_cmd.load_in) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_len  <= i_s_tdata[LEN_W-1:0];
            r_data <= i_s_tdata[LEN_W +: DATA_W];
        end
        case (i_cmd.upd)
            UPD_BEGIN, UPD_WORD, UPD_STRAY, UPD_EMPTY, UPD_CLEAR: begin
                r_res_word <= '0;
                r_res_last <= 1'b0;
                r_res_hlen <= '0;
                case (i_cmd.upd)
                    UPD_BEGIN: r_res_status <= bg_status;
                    UPD_STRAY: r_res_status <= ST_NO_OPEN;
                    UPD_EMPTY: r_res_status <= ST_EMPTY;
                    default:   r_res_status <= ST_OK;
                endcase
            end
            UPD_HEAD: begin
                r_head       <= rdata;
                r_res_status <= ST_ZERO_HEAD;
                r_res_word   <= '0;
                r_res_last   <= 1'b0;
                r_res_hlen   <= rdata[LEN_W-1:0];
            end
            UPD_READ: begin
                r_res_status <= ST_OK;
                r_res_word   <= rdata;
                r_res_last   <= 1'b0;
                r_res_hlen   <= r_head[LEN_W-1:0];
            end
            UPD_LINK: r_res_last <= 1'b1;
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_m_tdata <= {r_rem, r_acc, r_count, r_res_hlen, r_res_word};
            r_m_tuser <= r_res_status;
            r_m_tlast <= r_res_last;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;
endmodule
